>>> sv/mcph_pkg.sv
// Shared types, codes and arithmetic helpers for the multiplicative cipher core.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mcph_pkg;

  localparam int ALPHABET_MAX_DEF = 32;
  localparam int ALPHA_LIMIT      = 32;
  localparam int ALPHA_BITS       = ALPHA_LIMIT * 8;
  localparam int POS_W            = 5;
  localparam int SIZE_W           = 6;
  localparam int KEY_W            = 12;
  localparam int CFG_W            = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int QUEUE_DEPTH      = 2;
  localparam int MOD_STEPS        = KEY_W / 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA0 = 3'd0,
    REG_ALPHA1 = 3'd1,
    REG_ALPHA2 = 3'd2,
    REG_ALPHA3 = 3'd3,
    REG_SIZE   = 3'd4,
    REG_KEY    = 3'd5,
    REG_DIR    = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_NO_INVERSE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_KMOD,
    BK_EUCLID,
    BK_PMUL,
    BK_PMOD,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [ALPHA_BITS-1:0] alphabet;
    logic [SIZE_W-1:0]     size;
    logic [KEY_W-1:0]      key;
    logic                  decrypt;
  } cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] quo;
    logic [SIZE_W-1:0] rem;
  } div_t;

  // remainder of {rem, nib} modulo m, with rem < m
  function automatic logic [SIZE_W-1:0] mod_nib(logic [SIZE_W-1:0] rem,
                                                logic [3:0] nib,
                                                logic [SIZE_W-1:0] m);
    logic [SIZE_W:0] r;
    r = {1'b0, rem};
    for (int i = 3; i >= 0; i--) begin
      r = {r[SIZE_W-1:0], nib[i]};
      if (r >= {1'b0, m}) begin
        r = r - {1'b0, m};
      end
    end
    return r[SIZE_W-1:0];
  endfunction

  // restoring division of narrow operands, b nonzero
  function automatic div_t div6(logic [SIZE_W-1:0] a, logic [SIZE_W-1:0] b);
    logic [SIZE_W:0] r;
    div_t res;
    r = '0;
    res = '0;
    for (int i = SIZE_W - 1; i >= 0; i--) begin
      r = {r[SIZE_W-1:0], a[i]};
      if (r >= {1'b0, b}) begin
        r = r - {1'b0, b};
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r[SIZE_W-1:0];
    return res;
  endfunction

endpackage

>>> sv/mcph_front.sv
// Front end: looks up the incoming byte in the alphabet and classifies it.
// Depends on mcph_pkg.
`timescale 1ns / 1ps

module mcph_front #(
  parameter int ALPHABET_MAX = mcph_pkg::ALPHABET_MAX_DEF
) (
  input  logic [7:0]                       symbol_in,
  input  logic [mcph_pkg::ALPHA_BITS-1:0]  alphabet,
  input  logic [mcph_pkg::SIZE_W-1:0]      size,
  output mcph_pkg::item_t                  item
);

  always_comb begin
    item = '0;
    // scan downward so the lowest match wins
    for (int i = ALPHABET_MAX - 1; i >= 0; i--) begin
      if (mcph_pkg::SIZE_W'(i) < size && alphabet[i*8 +: 8] == symbol_in) begin
        item.found = 1'b1;
        item.pos   = mcph_pkg::POS_W'(i);
      end
    end
  end

endmodule

>>> sv/mcph_queue.sv
// Short queue of classified items between the front and back ends.
// Depends on mcph_pkg.
`timescale 1ns / 1ps

module mcph_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  mcph_pkg::item_t wdata,
  output logic            full,
  input  logic            rd,
  output mcph_pkg::item_t rdata,
  output logic            valid
);

  localparam int DEPTH = mcph_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mcph_pkg::item_t    mem [DEPTH];
  logic [PTR_W-1:0]   wptr;
  logic [PTR_W-1:0]   rptr;
  logic [CNT_W-1:0]   count;

  logic do_wr;
  logic do_rd;

  assign full  = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

>>> sv/mcph_back.sv
// Back end: key reduction, extended Euclid inverse, product modulo and result register.
// Depends on mcph_pkg.
`timescale 1ns / 1ps

module mcph_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mcph_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  input  mcph_pkg::item_t              q_item,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   symbol_out,
  output logic [1:0]                   status
);

  localparam int CNT_W = $clog2(mcph_pkg::MOD_STEPS);

  mcph_pkg::back_state_t state;
  mcph_pkg::back_state_t state_next;

  logic [mcph_pkg::POS_W-1:0]  pos;
  logic [mcph_pkg::POS_W-1:0]  mult;
  logic [mcph_pkg::KEY_W-1:0]  dat;
  logic [mcph_pkg::SIZE_W-1:0] rem;
  logic [CNT_W-1:0]            cnt;
  logic [mcph_pkg::SIZE_W-1:0] r0;
  logic [mcph_pkg::SIZE_W-1:0] r1;
  logic signed [7:0]           t0;
  logic signed [7:0]           t1;
  mcph_pkg::status_t           code;

  logic                        res_valid;
  logic [7:0]                  res_sym;
  mcph_pkg::status_t           res_status;
  logic                        res_free;
  logic                        res_load;

  logic [mcph_pkg::SIZE_W-1:0] rem_step;
  logic                        mod_last;
  mcph_pkg::div_t              dv;
  logic signed [14:0]          q_ext;
  logic signed [14:0]          t1_ext;
  logic signed [14:0]          qt;
  logic signed [14:0]          t2;
  logic signed [7:0]           m_s;
  logic signed [7:0]           t_norm;

  assign rem_step = mcph_pkg::mod_nib(rem, dat[mcph_pkg::KEY_W-1 -: 4], cfg.size);
  assign mod_last = (cnt == CNT_W'(mcph_pkg::MOD_STEPS - 1));
  assign dv       = mcph_pkg::div6(r0, r1);
  assign q_ext    = $signed({9'b0, dv.quo});
  assign t1_ext   = 15'(t1);
  assign qt       = q_ext * t1_ext;
  assign t2       = 15'(t0) - qt;
  assign m_s      = $signed({2'b0, cfg.size});

  always_comb begin
    if (t0 < 0) begin
      t_norm = t0 + m_s;
    end else if (t0 >= m_s) begin
      t_norm = t0 - m_s;
    end else begin
      t_norm = t0;
    end
  end

  assign res_free = !res_valid || pop;

  always_comb begin
    state_next = state;
    unique case (state)
      mcph_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = q_item.found ? mcph_pkg::BK_KMOD : mcph_pkg::BK_EMIT;
        end
      end
      mcph_pkg::BK_KMOD: begin
        if (mod_last) begin
          state_next = cfg.decrypt ? mcph_pkg::BK_EUCLID : mcph_pkg::BK_PMUL;
        end
      end
      mcph_pkg::BK_EUCLID: begin
        if (r1 == '0) begin
          state_next = (r0 == mcph_pkg::SIZE_W'(1)) ? mcph_pkg::BK_PMUL
                                                     : mcph_pkg::BK_EMIT;
        end
      end
      mcph_pkg::BK_PMUL: state_next = mcph_pkg::BK_PMOD;
      mcph_pkg::BK_PMOD: begin
        if (mod_last) begin
          state_next = mcph_pkg::BK_EMIT;
        end
      end
      mcph_pkg::BK_EMIT: begin
        if (res_free) begin
          state_next = mcph_pkg::BK_IDLE;
        end
      end
      default: state_next = mcph_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == mcph_pkg::BK_IDLE) && q_valid;
    res_load = (state == mcph_pkg::BK_EMIT) && res_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcph_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      mcph_pkg::BK_IDLE: begin
        if (q_pop) begin
          pos  <= q_item.pos;
          dat  <= cfg.key;
          rem  <= '0;
          cnt  <= '0;
          code <= q_item.found ? mcph_pkg::ST_OK : mcph_pkg::ST_NOT_FOUND;
        end
      end
      mcph_pkg::BK_KMOD: begin
        rem <= rem_step;
        dat <= {dat[mcph_pkg::KEY_W-5:0], 4'b0};
        cnt <= cnt + 1'b1;
        if (mod_last) begin
          mult <= rem_step[mcph_pkg::POS_W-1:0];
          r0   <= cfg.size;
          r1   <= rem_step;
          t0   <= 8'sd0;
          t1   <= 8'sd1;
        end
      end
      mcph_pkg::BK_EUCLID: begin
        if (r1 == '0) begin
          if (r0 == mcph_pkg::SIZE_W'(1)) begin
            mult <= t_norm[mcph_pkg::POS_W-1:0];
          end else begin
            code <= mcph_pkg::ST_NO_INVERSE;
          end
        end else begin
          r0 <= r1;
          r1 <= dv.rem;
          t0 <= t1;
          t1 <= t2[7:0];
        end
      end
      mcph_pkg::BK_PMUL: begin
        dat <= mcph_pkg::KEY_W'(10'(pos) * 10'(mult));
        rem <= '0;
        cnt <= '0;
      end
      mcph_pkg::BK_PMOD: begin
        rem <= rem_step;
        dat <= {dat[mcph_pkg::KEY_W-5:0], 4'b0};
        cnt <= cnt + 1'b1;
      end
      mcph_pkg::BK_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_sym    <= (code == mcph_pkg::ST_OK) ?
                    cfg.alphabet[{rem[mcph_pkg::POS_W-1:0], 3'b0} +: 8] : 8'd0;
      res_status <= code;
    end
  end

  assign empty      = !res_valid;
  assign symbol_out = res_sym;
  assign status     = res_status;

endmodule

>>> sv/multiplicative_cipher_core.sv
// Multiplicative substitution cipher over a configurable alphabet of up to 32 bytes.
// Depends on mcph_pkg, mcph_front, mcph_queue, mcph_back.
`timescale 1ns / 1ps

// Each byte pushed is looked up in the alphabet on entry and queued; the back
// end maps its position p to the entry at (p * k) mod size, where k is the key
// (encrypt) or its inverse found by extended Euclid (decrypt), and returns one
// result item per input item in order. A byte not in the alphabet returns
// status 1. Encrypt reduces the key and then the product modulo size, a
// nibble per cycle, with the multiply between them, after the queue pop and
// before the result load. Decrypt adds an extended Euclid step per quotient
// and a final check; an uninvertible key returns status 2. The back end
// sequencer works on one item at a time and sets the rate; the front keeps
// taking items into a two-entry queue while it runs. Configuration writes
// take effect at once and belong in idle periods.
module multiplicative_cipher_core #(
  parameter int ALPHABET_MAX = mcph_pkg::ALPHABET_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [7:0]                      symbol_in,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      symbol_out,
  output logic [1:0]                      status,
  input  logic                            cfg_we,
  input  logic [mcph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcph_pkg::CFG_W-1:0]      cfg_data
);

  logic [mcph_pkg::CFG_W-1:0]  alpha_word [4];
  logic [mcph_pkg::SIZE_W-1:0] alphabet_size;
  logic [mcph_pkg::KEY_W-1:0]  cipher_key;
  logic                        direction;

  logic [mcph_pkg::SIZE_W-1:0] eff_size;
  mcph_pkg::cfg_t              cfg;
  mcph_pkg::item_t             f_item;
  mcph_pkg::item_t             q_item;
  logic                        q_valid;
  logic                        q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_word[0] <= '0;
      alpha_word[1] <= '0;
      alpha_word[2] <= '0;
      alpha_word[3] <= '0;
      alphabet_size <= mcph_pkg::SIZE_W'(1);
      cipher_key    <= mcph_pkg::KEY_W'(1);
      direction     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcph_pkg::REG_ALPHA0: alpha_word[0] <= cfg_data;
        mcph_pkg::REG_ALPHA1: alpha_word[1] <= cfg_data;
        mcph_pkg::REG_ALPHA2: alpha_word[2] <= cfg_data;
        mcph_pkg::REG_ALPHA3: alpha_word[3] <= cfg_data;
        mcph_pkg::REG_SIZE:   alphabet_size <= cfg_data[mcph_pkg::SIZE_W-1:0];
        mcph_pkg::REG_KEY:    cipher_key    <= cfg_data[mcph_pkg::KEY_W-1:0];
        mcph_pkg::REG_DIR:    direction     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (alphabet_size == '0) begin
      eff_size = mcph_pkg::SIZE_W'(1);
    end else if (alphabet_size > mcph_pkg::SIZE_W'(ALPHABET_MAX)) begin
      eff_size = mcph_pkg::SIZE_W'(ALPHABET_MAX);
    end else begin
      eff_size = alphabet_size;
    end
  end

  always_comb begin
    cfg.alphabet = {alpha_word[3], alpha_word[2], alpha_word[1], alpha_word[0]};
    cfg.size     = eff_size;
    cfg.key      = cipher_key;
    cfg.decrypt  = direction;
  end

  mcph_front #(
    .ALPHABET_MAX (ALPHABET_MAX)
  ) u_front (
    .symbol_in (symbol_in),
    .alphabet  (cfg.alphabet),
    .size      (eff_size),
    .item      (f_item)
  );

  mcph_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (f_item),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_item),
    .valid (q_valid)
  );

  mcph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .symbol_out (symbol_out),
    .status     (status)
  );

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != mcph_pkg::ST_OK) |-> (symbol_out == 8'd0))
    else $error("error result carries a nonzero byte");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_hold_stable: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(symbol_out) && $stable(status)))
    else $error("waiting result item changed or was lost");

endmodule
